/* hw/rtl/sslt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sslt_pkg
// Shared types and codes for the sorted slot list table.
// ----------------------------------------------------------------------------
package sslt_pkg;

	localparam logic [7:0] EMPTY_MARK      = 8'hFF;
	localparam logic [7:0] MAX_VALUE_RESET = 8'd100;

	// command codes
	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_DELETE = 2'd1;
	localparam logic [1:0] CMD_READ   = 2'd2;

	// status codes
	localparam logic [2:0] STAT_OK         = 3'd0;
	localparam logic [2:0] STAT_SLOT_RANGE = 3'd1;
	localparam logic [2:0] STAT_OCCUPIED   = 3'd2;
	localparam logic [2:0] STAT_VAL_RANGE  = 3'd3;
	localparam logic [2:0] STAT_DUPLICATE  = 3'd4;
	localparam logic [2:0] STAT_NOT_FOUND  = 3'd5;
	localparam logic [2:0] STAT_SLOT_EMPTY = 3'd6;

	typedef struct packed {
		logic [1:0] command;
		logic [5:0] slot;
		logic [7:0] value;
	} req_t;

	typedef struct packed {
		logic [2:0] status;
		logic [7:0] slot_value;
		logic [5:0] next_slot;
		logic [5:0] head_slot;
		logic [5:0] touched_slot;
	} res_t;

endpackage

/* hw/rtl/sslt_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sslt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sslt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* hw/rtl/sorted_slot_list_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_slot_list_table
// Slot table kept as an ascending list: insert, delete by value, read slot.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake              payload
//  -------   ---  ---------------------  ---------------------------
//  req       in   req_valid / req_stall  req_data   (sslt_pkg::req_t)
//  res       out  res_valid / res_stall  res_data   (sslt_pkg::res_t)
//  cfg       in   cfg_we                 cfg_data   (max_value)
//
//  Steps: a request makes one read of the addressed slot, one pass over all
//  SLOTS entries through the single RAM read port and one finish step, then
//  the table is ready again.
//  Reset: arst_n clears the per-slot valid bits at once, so every slot reads
//  empty right after reset; no clearing pass. max_value resets to 100.
//  Stalls: the result sits in an output register; the next request is taken
//  while it waits. A second result waits in the finish cycle until the
//  output register frees up.
//
// Operation
//  Values live in a RAM. A valid bit per slot (flip-flops) marks occupied
//  slots; an invalid slot reads as the empty mark. A request runs:
//   PRE  : addressed slot's value comes back (its old contents).
//   SCAN : every slot streams out once; in the same pass we collect
//          - the first slot matching the request value (duplicate / delete),
//          - the smallest value, skipping the value being deleted (new head),
//          - the smallest value above the addressed slot's value (successor).
//   FIN  : status is decided, the RAM / valid bits are updated, result out.
//  Values are unique in the table, so "smallest" never has ties.
// ----------------------------------------------------------------------------
module sorted_slot_list_table #(
	parameter int SLOTS = 32
) (
	input  logic            clk,
	input  logic            arst_n,
	// request channel
	input  logic            req_valid,
	output logic            req_stall,
	input  sslt_pkg::req_t  req_data,
	// result channel
	output logic            res_valid,
	input  logic            res_stall,
	output sslt_pkg::res_t  res_data,
	// config
	input  logic            cfg_we,
	input  logic [7:0]      cfg_data
);

	localparam int AW = $clog2(SLOTS);
	localparam int CW = $clog2(SLOTS + 1);
	localparam logic [5:0]    NO_SLOT   = 6'(SLOTS);
	localparam logic [CW-1:0] SCAN_LAST = CW'(SLOTS);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_PRE  = 2'd1;
	localparam logic [1:0] ST_SCAN = 2'd2;
	localparam logic [1:0] ST_FIN  = 2'd3;

	// control
	logic [1:0]       state_q;
	logic [CW-1:0]    iss_q;       // next slot index to issue during the scan
	logic [SLOTS-1:0] valid_q;     // slot occupied
	logic [7:0]       max_value_q;
	logic             res_valid_q;

	// request and scan results
	sslt_pkg::req_t req_q;
	logic [7:0]     sval_q;        // addressed slot contents
	logic           mfound_q;
	logic [AW-1:0]  midx_q;
	logic           hfound_q;
	logic [7:0]     hmin_q;
	logic [AW-1:0]  hidx_q;
	logic           sfound_q;
	logic [7:0]     smin_q;
	logic [AW-1:0]  sidx_q;
	sslt_pkg::res_t res_q;

	// RAM read path
	logic [AW-1:0] rd_addr;
	logic [7:0]    rd_data;
	logic          rdv_s1;
	logic [AW-1:0] ridx_s1;
	logic [7:0]    entry;
	logic          occ;

	logic          accept;
	logic          in_slot_ok;
	logic          slot_ok;
	logic [AW-1:0] slot_idx;
	logic          vbad;
	logic          excl;
	logic          fin_go;

	// finish decision
	logic [2:0]     stat;
	logic           do_ins;
	logic           do_del;
	sslt_pkg::res_t res_nxt;

	assign accept     = req_valid && !req_stall;
	assign req_stall  = (state_q != ST_IDLE);
	assign in_slot_ok = (req_data.slot < NO_SLOT);
	assign slot_ok    = (req_q.slot < NO_SLOT);
	assign slot_idx   = slot_ok ? req_q.slot[AW-1:0] : '0;
	assign vbad       = (req_q.value == sslt_pkg::EMPTY_MARK) || (req_q.value > max_value_q);
	// deleted value drops out of the head search
	assign excl       = (req_q.command == sslt_pkg::CMD_DELETE) && !vbad;
	assign fin_go     = (state_q == ST_FIN) && (!res_valid_q || !res_stall);

	always_comb begin
		rd_addr = '0;
		unique case (state_q)
			ST_IDLE: rd_addr = in_slot_ok ? req_data.slot[AW-1:0] : '0;
			ST_PRE:  rd_addr = '0;
			ST_SCAN: rd_addr = (iss_q < SCAN_LAST) ? iss_q[AW-1:0] : '0;
			ST_FIN:  rd_addr = '0;
			default: rd_addr = '0;
		endcase
	end

	sslt_ram #(
		.WIDTH (8),
		.DEPTH (SLOTS)
	) u_ram (
		.clk   (clk),
		.we    (fin_go && do_ins),
		.waddr (slot_idx),
		.wdata (req_q.value),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	always_ff @(posedge clk) begin
		rdv_s1  <= valid_q[rd_addr];
		ridx_s1 <= rd_addr;
	end

	assign occ   = rdv_s1;
	assign entry = rdv_s1 ? rd_data : sslt_pkg::EMPTY_MARK;

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			iss_q       <= '0;
			valid_q     <= '0;
			max_value_q <= sslt_pkg::MAX_VALUE_RESET;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				max_value_q <= cfg_data;
			end
			// a new result loads the output register, else a taken one leaves
			if (fin_go) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_PRE;
					end
				end
				ST_PRE: begin
					iss_q   <= CW'(1);
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (iss_q == SCAN_LAST) begin
						state_q <= ST_FIN;
					end else begin
						iss_q <= iss_q + CW'(1);
					end
				end
				ST_FIN: begin
					if (fin_go) begin
						state_q <= ST_IDLE;
						if (do_ins) begin
							valid_q[slot_idx] <= 1'b1;
						end
						if (do_del) begin
							valid_q[midx_q] <= 1'b0;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// request capture and scan accumulators
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req_data;
		end
		if (state_q == ST_PRE) begin
			sval_q   <= slot_ok ? entry : sslt_pkg::EMPTY_MARK;
			mfound_q <= 1'b0;
			hfound_q <= 1'b0;
			sfound_q <= 1'b0;
		end
		if (state_q == ST_SCAN) begin
			if (occ && !mfound_q && (entry == req_q.value)) begin
				mfound_q <= 1'b1;
				midx_q   <= ridx_s1;
			end
			if (occ && !(excl && (entry == req_q.value)) && (!hfound_q || (entry < hmin_q))) begin
				hfound_q <= 1'b1;
				hmin_q   <= entry;
				hidx_q   <= ridx_s1;
			end
			if (occ && (entry > sval_q) && (!sfound_q || (entry < smin_q))) begin
				sfound_q <= 1'b1;
				smin_q   <= entry;
				sidx_q   <= ridx_s1;
			end
		end
		if (fin_go) begin
			res_q <= res_nxt;
		end
	end

	// status and result
	always_comb begin
		stat   = sslt_pkg::STAT_OK;
		do_ins = 1'b0;
		do_del = 1'b0;
		unique case (req_q.command)
			sslt_pkg::CMD_INSERT: begin
				priority if (!slot_ok)                        stat = sslt_pkg::STAT_SLOT_RANGE;
				else if (sval_q != sslt_pkg::EMPTY_MARK)      stat = sslt_pkg::STAT_OCCUPIED;
				else if (vbad)                                stat = sslt_pkg::STAT_VAL_RANGE;
				else if (mfound_q)                            stat = sslt_pkg::STAT_DUPLICATE;
				else                                          do_ins = 1'b1;
			end
			sslt_pkg::CMD_DELETE: begin
				priority if (vbad)   stat = sslt_pkg::STAT_VAL_RANGE;
				else if (!mfound_q)  stat = sslt_pkg::STAT_NOT_FOUND;
				else                 do_del = 1'b1;
			end
			sslt_pkg::CMD_READ: begin
				priority if (!slot_ok)                        stat = sslt_pkg::STAT_SLOT_RANGE;
				else if (sval_q == sslt_pkg::EMPTY_MARK)      stat = sslt_pkg::STAT_SLOT_EMPTY;
				else                                          stat = sslt_pkg::STAT_OK;
			end
			default: stat = sslt_pkg::STAT_OK;
		endcase

		res_nxt.status     = stat;
		res_nxt.slot_value = sslt_pkg::EMPTY_MARK;
		res_nxt.next_slot  = NO_SLOT;
		if ((req_q.command == sslt_pkg::CMD_READ) && (stat == sslt_pkg::STAT_OK)) begin
			res_nxt.slot_value = sval_q;
			res_nxt.next_slot  = sfound_q ? 6'(sidx_q) : NO_SLOT;
		end

		// head after the update: an insert may undercut the scanned minimum
		res_nxt.head_slot = hfound_q ? 6'(hidx_q) : NO_SLOT;
		if (do_ins && (!hfound_q || (req_q.value < hmin_q))) begin
			res_nxt.head_slot = 6'(slot_idx);
		end

		res_nxt.touched_slot = NO_SLOT;
		if (do_ins) begin
			res_nxt.touched_slot = 6'(slot_idx);
		end else if (do_del) begin
			res_nxt.touched_slot = 6'(midx_q);
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

endmodule

/* hw/rtl/sslt_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sslt_checker
// Port-level checks for the sorted slot list table.
// ----------------------------------------------------------------------------
module sslt_checker #(
	parameter int SLOTS = 32
) (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_stall,
	input logic           res_valid,
	input logic           res_stall,
	input sslt_pkg::res_t res_data
);

	localparam logic [5:0] NO_SLOT = 6'(SLOTS);

	// held result stays put
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res_data))
		else $error("result changed while stalled");

	// one request at a time
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request taken while busy");

	// a failed request changes no slot
	a_fail_untouched: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_data.status != sslt_pkg::STAT_OK) |-> res_data.touched_slot == NO_SLOT)
		else $error("failed request touched a slot");

	// only a good read returns a value, and a read writes nothing
	a_read_shape: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_data.slot_value != sslt_pkg::EMPTY_MARK)
		|-> (res_data.status == sslt_pkg::STAT_OK) && (res_data.touched_slot == NO_SLOT))
		else $error("bad read result");

endmodule

bind sorted_slot_list_table sslt_checker #(.SLOTS(SLOTS)) u_sslt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.res_data  (res_data)
);
